FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the block checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/tfrb_pkg.sv
// ----------------------------------------------------------------------------
// tfrb_pkg
// types and codes shared by the tagged frame ring buffer modules
// ----------------------------------------------------------------------------
package tfrb_pkg;

	// request codes
	localparam logic [1:0] REQ_LOOKUP   = 2'd0;
	localparam logic [1:0] REQ_ALLOC    = 2'd1;
	localparam logic [1:0] REQ_DISPATCH = 2'd2;

	// response status codes
	localparam logic [2:0] ST_FOUND    = 3'd0;
	localparam logic [2:0] ST_CREATED  = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_ALLOC    = 3'd3;
	localparam logic [2:0] ST_DISPATCH = 3'd4;
	localparam logic [2:0] ST_EMPTY    = 3'd5;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] frame_id;
		logic        create_new;
	} req_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] slot_index;
		logic       reclaimed;
		logic [3:0] reclaimed_slot;
		logic [4:0] frames_queued;
	} rsp_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_LKP,
		S_KEY_A,
		S_KEY_B,
		S_KEY_C,
		S_UNTAG,
		S_COMMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic scan_clr;
		logic scan_run;
		logic scan_untag;
		logic rd_send;
		logic rd_sent;
		logic cap_a;
		logic cap_b;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] req;
		logic       create;
		logic       hit;
		logic       full;
		logic       empty;
		logic       scan_done;
		logic       out_busy;
	} sts_t;

endpackage

FILE: hw/rtl/tfrb_ram.sv
// ----------------------------------------------------------------------------
// tfrb_ram
// generic one-write one-read RAM with registered read data
// ----------------------------------------------------------------------------
module tfrb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/tfrb_ctrl.sv
// ----------------------------------------------------------------------------
// tfrb_ctrl
// request sequencer: scan, key fetch, untag sweep and commit
// ----------------------------------------------------------------------------
module tfrb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  tfrb_pkg::sts_t  sts,
	output tfrb_pkg::cmd_t  cmd
);

	tfrb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfrb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tfrb_pkg::S_IDLE: begin
				if (req_valid) state_d = tfrb_pkg::S_DECIDE;
			end
			tfrb_pkg::S_DECIDE: begin
				if (sts.req == tfrb_pkg::REQ_LOOKUP) begin
					state_d = tfrb_pkg::S_LKP;
				end else if (sts.req == tfrb_pkg::REQ_ALLOC) begin
					state_d = sts.full ? tfrb_pkg::S_KEY_A : tfrb_pkg::S_COMMIT;
				end else if (sts.req == tfrb_pkg::REQ_DISPATCH) begin
					state_d = sts.empty ? tfrb_pkg::S_COMMIT : tfrb_pkg::S_KEY_A;
				end else begin
					state_d = tfrb_pkg::S_COMMIT;
				end
			end
			tfrb_pkg::S_LKP: begin
				if (sts.scan_done) begin
					// create on a full ring overwrites the oldest unsent slot first
					if (!sts.hit && sts.create && sts.full) state_d = tfrb_pkg::S_KEY_A;
					else state_d = tfrb_pkg::S_COMMIT;
				end
			end
			tfrb_pkg::S_KEY_A: state_d = tfrb_pkg::S_KEY_B;
			tfrb_pkg::S_KEY_B: state_d = tfrb_pkg::S_KEY_C;
			tfrb_pkg::S_KEY_C: state_d = tfrb_pkg::S_UNTAG;
			tfrb_pkg::S_UNTAG: begin
				if (sts.scan_done) state_d = tfrb_pkg::S_COMMIT;
			end
			tfrb_pkg::S_COMMIT: begin
				if (!sts.out_busy) state_d = tfrb_pkg::S_IDLE;
			end
			default: state_d = tfrb_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			tfrb_pkg::S_IDLE: begin
				req_stall    = 1'b0;
				cmd.latch    = req_valid;
				cmd.scan_clr = req_valid;
			end
			tfrb_pkg::S_DECIDE: ;
			tfrb_pkg::S_LKP: begin
				cmd.scan_run = 1'b1;
			end
			tfrb_pkg::S_KEY_A: begin
				cmd.rd_send = 1'b1;
			end
			tfrb_pkg::S_KEY_B: begin
				cmd.rd_sent = 1'b1;
				cmd.cap_a   = 1'b1;
			end
			tfrb_pkg::S_KEY_C: begin
				cmd.cap_b    = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			tfrb_pkg::S_UNTAG: begin
				cmd.scan_run   = 1'b1;
				cmd.scan_untag = 1'b1;
			end
			tfrb_pkg::S_COMMIT: begin
				cmd.commit = !sts.out_busy;
			end
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/tfrb_datapath.sv
// ----------------------------------------------------------------------------
// tfrb_datapath
// slot id memory, tag bits, ring pointers, scan pipeline and response register
// ----------------------------------------------------------------------------
module tfrb_datapath #(
	parameter int SLOTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tfrb_pkg::req_word_t  req,
	input  tfrb_pkg::cmd_t       cmd,
	output tfrb_pkg::sts_t       sts,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output tfrb_pkg::rsp_word_t  rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
		return (p == IW'(SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

	// latched request
	logic [1:0]  req_q;
	logic [31:0] id_q;
	logic        create_q;

	// ring state
	logic [IW-1:0] free_q, send_q, sent_q;
	logic          sent_v_q;
	logic [CW-1:0] used_q;
	logic          tagged_q  [SLOTS];
	logic          written_q [SLOTS];

	// scan
	logic [CW-1:0] cnt_q;
	logic          cmp_v_s1;
	logic          untag_s1;
	logic [IW-1:0] idx_s1;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [31:0]   key_a_q, key_b_q;

	// memory
	logic [IW-1:0] raddr;
	logic [31:0]   rdata;
	logic          ram_we;

	logic          full;
	logic          use_b;
	logic [31:0]   cmp_val;
	logic          untag_hit;
	logic          scan_issue;

	// commit results
	logic [2:0]    c_status;
	logic [IW-1:0] c_idx;
	logic          c_rec;
	logic [IW-1:0] c_rslot;
	logic [IW-1:0] free_d, send_d, sent_d;
	logic          sent_v_d;
	logic [CW-1:0] used_d;
	logic          take;
	logic          tag_wr;

	logic          rsp_valid_q;
	tfrb_pkg::rsp_word_t rsp_q;

	assign full       = used_q >= CW'(SLOTS);
	assign use_b      = (req_q == tfrb_pkg::REQ_DISPATCH) && sent_v_q;
	assign scan_issue = cmd.scan_run && (cnt_q < CW'(SLOTS));
	assign cmp_val    = written_q[idx_s1] ? rdata : '0;
	assign untag_hit  = (cmp_val == key_a_q) || (use_b && (cmp_val == key_b_q));
	assign ram_we     = cmd.commit && tag_wr;

	always_comb begin
		if (cmd.rd_send) raddr = send_q;
		else if (cmd.rd_sent) raddr = sent_q;
		else raddr = cnt_q[IW-1:0];
	end

	tfrb_ram #(
		.WIDTH (32),
		.DEPTH (SLOTS)
	) u_id_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_q),
		.wdata (id_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q    <= req.req_type;
			id_q     <= req.frame_id;
			create_q <= req.create_new;
		end
		// never-written slots read as id zero
		if (cmd.cap_a) key_a_q <= written_q[send_q] ? rdata : '0;
		if (cmd.cap_b) key_b_q <= written_q[sent_q] ? rdata : '0;
		idx_s1   <= cnt_q[IW-1:0];
		untag_s1 <= cmd.scan_untag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			cmp_v_s1 <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			cmp_v_s1 <= scan_issue;
			if (cmd.scan_clr) cnt_q <= '0;
			else if (scan_issue) cnt_q <= cnt_q + 1'b1;
			if (cmd.latch) begin
				hit_q <= 1'b0;
			end else if (cmp_v_s1 && !untag_s1 && !hit_q && tagged_q[idx_s1]
					&& (cmp_val == id_q)) begin
				// first match wins: lowest index
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_v_s1 && !untag_s1 && !hit_q) hit_idx_q <= idx_s1;
	end

	always_comb begin
		c_status = tfrb_pkg::ST_NOTFOUND;
		c_idx    = '0;
		c_rec    = 1'b0;
		c_rslot  = '0;
		free_d   = free_q;
		send_d   = send_q;
		sent_d   = sent_q;
		sent_v_d = sent_v_q;
		used_d   = used_q;
		take     = 1'b0;
		tag_wr   = 1'b0;
		unique case (req_q)
			tfrb_pkg::REQ_LOOKUP: begin
				if (hit_q) begin
					c_status = tfrb_pkg::ST_FOUND;
					c_idx    = hit_idx_q;
				end else if (create_q) begin
					take     = 1'b1;
					tag_wr   = 1'b1;
					c_status = tfrb_pkg::ST_CREATED;
				end
			end
			tfrb_pkg::REQ_ALLOC: begin
				take     = 1'b1;
				c_status = tfrb_pkg::ST_ALLOC;
			end
			tfrb_pkg::REQ_DISPATCH: begin
				if (used_q == '0) begin
					c_status = tfrb_pkg::ST_EMPTY;
				end else begin
					c_idx = send_q;
					if (sent_v_q) begin
						c_rec   = 1'b1;
						c_rslot = sent_q;
						used_d  = used_q - 1'b1;
					end
					sent_d   = send_q;
					sent_v_d = 1'b1;
					send_d   = ring_next(send_q);
					c_status = tfrb_pkg::ST_DISPATCH;
				end
			end
			default: ;
		endcase
		if (take) begin
			c_idx = free_q;
			if (full) begin
				c_rec   = 1'b1;
				c_rslot = send_q;
				send_d  = ring_next(send_q);
			end else begin
				used_d = used_q + 1'b1;
			end
			free_d = ring_next(free_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q   <= '0;
			send_q   <= '0;
			sent_q   <= '0;
			sent_v_q <= 1'b0;
			used_q   <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				tagged_q[i]  <= 1'b0;
				written_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.commit) begin
				free_q   <= free_d;
				send_q   <= send_d;
				sent_q   <= sent_d;
				sent_v_q <= sent_v_d;
				used_q   <= used_d;
			end
			for (int i = 0; i < SLOTS; i++) begin
				if (ram_we && (free_q == IW'(i))) begin
					tagged_q[i]  <= 1'b1;
					written_q[i] <= 1'b1;
				end else if (cmp_v_s1 && untag_s1 && (idx_s1 == IW'(i)) && untag_hit) begin
					tagged_q[i] <= 1'b0;
				end
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.status         <= c_status;
			rsp_q.slot_index     <= 4'(c_idx);
			rsp_q.reclaimed      <= c_rec;
			rsp_q.reclaimed_slot <= 4'(c_rslot);
			rsp_q.frames_queued  <= 5'(used_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign sts.req       = req_q;
	assign sts.create    = create_q;
	assign sts.hit       = hit_q;
	assign sts.full      = full;
	assign sts.empty     = (used_q == '0);
	assign sts.scan_done = (cnt_q == CW'(SLOTS)) && !cmp_v_s1;
	assign sts.out_busy  = rsp_valid_q && rsp_stall;

endmodule

FILE: hw/rtl/tagged_frame_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// tagged_frame_ring_buffer_top
// ring of frame slots with id tags: lookup or create, allocate, dispatch
// ----------------------------------------------------------------------------
// One request word is taken at a time and answered with one response word.
// Slot ids live in a single-port-read RAM, so every search over the slots
// walks it one slot per cycle. An allocate that does not overwrite, a dispatch
// on an empty ring or an unused request code is answered without a walk over
// the slots; a lookup scans the ring; a dispatch, or an allocate on a full
// ring, fetches the ids to release and sweeps the ring to drop their tags; a
// create on a full ring does both walks. The next request is accepted in the
// cycle after the response is written. The response sits in an output
// register, so the next request is accepted while a response is still
// waiting to be taken; that request's response is held back for as long as
// the earlier one stays stalled.
module tagged_frame_ring_buffer_top #(
	parameter int SLOTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  tfrb_pkg::req_word_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output tfrb_pkg::rsp_word_t  rsp
);

	tfrb_pkg::cmd_t cmd;
	tfrb_pkg::sts_t sts;

	tfrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tfrb_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: hw/rtl/tfrb_checker.sv
// ----------------------------------------------------------------------------
// tfrb_checker
// port-level checks on the tagged frame ring buffer response channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfrb_checker #(
	parameter int SLOTS = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_stall,
	input tfrb_pkg::rsp_word_t  rsp
);

	// count of used slots never exceeds the ring
	`ASSERT_IMPLY(a_queued_bound, clk, arst_n, rsp_valid, (32'(rsp.frames_queued) <= SLOTS))

	// nothing reclaimed means reclaimed slot reads zero
	`ASSERT_IMPLY(a_rec_slot_zero, clk, arst_n, rsp_valid && !rsp.reclaimed, (rsp.reclaimed_slot == 4'd0))

	// no slot in the answer means index zero
	`ASSERT_IMPLY(a_idx_zero, clk, arst_n, rsp_valid && ((rsp.status == tfrb_pkg::ST_NOTFOUND) || (rsp.status == tfrb_pkg::ST_EMPTY)), (rsp.slot_index == 4'd0))

	// a stalled response word holds
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind tagged_frame_ring_buffer_top tfrb_checker #(
	.SLOTS (SLOTS)
) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the tagged frame ring buffer against a slot-ring predictor
// ----------------------------------------------------------------------------
// Request words come from a queue filled phase by phase: a directed walk that
// fills the ring and overwrites it, then random lookups, allocates and
// dispatches over a small id pool so tags get hit, dropped and overwritten.
// Every accepted request is run through the predictor; every accepted
// response is checked field by field against the oldest prediction.
module tb_top;

	localparam int SLOTS = 16;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int ID_POOL = 20;
	localparam int HOLD_CYCLES = 300;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	tfrb_pkg::req_word_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	tfrb_pkg::rsp_word_t rsp;

	tagged_frame_ring_buffer_top #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predictor copy of the ring; 4-bit pointers wrap on their own at 16 slots
	logic [31:0] tag_id [SLOTS] = '{default: '0};
	logic        tag_on [SLOTS] = '{default: 1'b0};
	logic [3:0]  free_ptr = '0;
	logic [3:0]  send_ptr = '0;
	logic [3:0]  sent_ptr = '0;
	logic        sent_known = 1'b0;
	logic [4:0]  used_cnt = '0;

	tfrb_pkg::req_word_t pending_req [$];
	tfrb_pkg::rsp_word_t expected_rsp [$];
	logic [31:0] id_pool [ID_POOL];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errors = 0;
	bit take_next;
	tfrb_pkg::rsp_word_t want;

	function automatic void drop_tag(logic [31:0] id);
		for (int i = 0; i < SLOTS; i++)
			if (tag_on[i] && tag_id[i] == id)
				tag_on[i] = 1'b0;
	endfunction

	// next free slot; on a full ring the oldest unsent slot is overwritten
	function automatic logic [3:0] claim_slot(inout tfrb_pkg::rsp_word_t o);
		logic [3:0] s;
		s = free_ptr;
		if (used_cnt >= SLOTS) begin
			drop_tag(tag_id[send_ptr]);
			o.reclaimed = 1'b1;
			o.reclaimed_slot = send_ptr;
			send_ptr = send_ptr + 1'b1;
		end else begin
			used_cnt = used_cnt + 1'b1;
		end
		free_ptr = free_ptr + 1'b1;
		return s;
	endfunction

	function automatic tfrb_pkg::rsp_word_t predict_response(tfrb_pkg::req_word_t r);
		tfrb_pkg::rsp_word_t o;
		int hit_at;
		o = '0;
		o.status = tfrb_pkg::ST_NOTFOUND;
		hit_at = -1;
		case (r.req_type)
			tfrb_pkg::REQ_LOOKUP: begin
				// lowest matching slot wins
				for (int i = SLOTS - 1; i >= 0; i--)
					if (tag_on[i] && tag_id[i] == r.frame_id)
						hit_at = i;
				if (hit_at >= 0) begin
					o.status = tfrb_pkg::ST_FOUND;
					o.slot_index = hit_at[3:0];
				end else if (r.create_new) begin
					o.slot_index = claim_slot(o);
					tag_id[o.slot_index] = r.frame_id;
					tag_on[o.slot_index] = 1'b1;
					o.status = tfrb_pkg::ST_CREATED;
				end
			end
			tfrb_pkg::REQ_ALLOC: begin
				o.slot_index = claim_slot(o);
				o.status = tfrb_pkg::ST_ALLOC;
			end
			tfrb_pkg::REQ_DISPATCH: begin
				if (used_cnt == 0) begin
					o.status = tfrb_pkg::ST_EMPTY;
				end else begin
					o.slot_index = send_ptr;
					drop_tag(tag_id[send_ptr]);
					// the slot sent before is released only now
					if (sent_known) begin
						drop_tag(tag_id[sent_ptr]);
						o.reclaimed = 1'b1;
						o.reclaimed_slot = sent_ptr;
						used_cnt = used_cnt - 1'b1;
					end
					sent_ptr = send_ptr;
					sent_known = 1'b1;
					send_ptr = send_ptr + 1'b1;
					o.status = tfrb_pkg::ST_DISPATCH;
				end
			end
			default: begin
			end
		endcase
		o.frames_queued = used_cnt;
		return o;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			take_next = !req_valid;
			if (req_valid && !req_stall) begin
				expected_rsp.push_back(predict_response(req));
				take_next = 1'b1;
			end
			if (take_next) begin
				if (pending_req.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= pending_req.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response side stall, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic note_mismatch(string what, int unsigned exp_v, int unsigned got_v);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
		errors++;
	endtask

	// response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t: response word with none expected, expected none, actual %h",
					$time, rsp);
				errors++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status)
					note_mismatch("status", want.status, rsp.status);
				if (rsp.slot_index !== want.slot_index)
					note_mismatch("slot_index", want.slot_index, rsp.slot_index);
				if (rsp.reclaimed !== want.reclaimed)
					note_mismatch("reclaimed", want.reclaimed, rsp.reclaimed);
				if (rsp.reclaimed_slot !== want.reclaimed_slot)
					note_mismatch("reclaimed_slot", want.reclaimed_slot, rsp.reclaimed_slot);
				if (rsp.frames_queued !== want.frames_queued)
					note_mismatch("frames_queued", want.frames_queued, rsp.frames_queued);
			end
		end
	end

	task automatic push_req(logic [1:0] kind, logic [31:0] id, logic create);
		tfrb_pkg::req_word_t w;
		w.req_type = kind;
		w.frame_id = id;
		w.create_new = create;
		pending_req.push_back(w);
	endtask

	// mostly lookups over a small id pool so hits and creates both happen
	task automatic push_random_req();
		int pick;
		logic [31:0] id;
		pick = $urandom_range(99);
		id = ($urandom_range(99) < 75) ? id_pool[$urandom_range(ID_POOL - 1)] : $urandom;
		if (pick < 50)
			push_req(tfrb_pkg::REQ_LOOKUP, id, $urandom_range(99) < 70);
		else if (pick < 70)
			push_req(tfrb_pkg::REQ_ALLOC, $urandom, 1'($urandom_range(1)));
		else if (pick < 95)
			push_req(tfrb_pkg::REQ_DISPATCH, $urandom, 1'($urandom_range(1)));
		else
			push_req(REQ_UNUSED, id, 1'($urandom_range(1)));
	endtask

	task automatic wait_drained();
		while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int idle, int stall, int count);
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (count)
			push_random_req();
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < ID_POOL; i++)
			id_pool[i] = $urandom;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed walk: empty ring, extreme ids, fill up, overwrite, dispatch
		push_req(tfrb_pkg::REQ_DISPATCH, 32'h0, 1'b0);
		push_req(tfrb_pkg::REQ_LOOKUP, 32'h0, 1'b0);
		push_req(REQ_UNUSED, 32'hffff_ffff, 1'b1);
		push_req(tfrb_pkg::REQ_LOOKUP, 32'h0, 1'b1);
		push_req(tfrb_pkg::REQ_LOOKUP, 32'h0, 1'b1);
		push_req(tfrb_pkg::REQ_LOOKUP, 32'hffff_ffff, 1'b1);
		push_req(tfrb_pkg::REQ_ALLOC, 32'h0, 1'b0);
		for (int k = 0; k < 13; k++)
			push_req(tfrb_pkg::REQ_LOOKUP, 32'h1 << k, 1'b1);
		push_req(tfrb_pkg::REQ_LOOKUP, 32'h8000_0000, 1'b1);
		push_req(tfrb_pkg::REQ_ALLOC, 32'h0, 1'b1);
		push_req(tfrb_pkg::REQ_DISPATCH, 32'h0, 1'b0);
		push_req(tfrb_pkg::REQ_DISPATCH, 32'h0, 1'b0);
		push_req(tfrb_pkg::REQ_LOOKUP, 32'hffff_ffff, 1'b0);
		wait_drained();

		run_phase(0, 0, 140);
		run_phase(63, 0, 140);
		run_phase(0, 63, 140);
		run_phase(25, 25, 140);

		// receiver holds off while requests keep coming, so the block backs up
		send_idle_pct = 0;
		stall_pct = 0;
		hold_asks = hold_asks + 1;
		repeat (40)
			push_random_req();
		wait_drained();

		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
